// ===== design/rsa_pkg.sv =====
// Package for the RPN stack adder: codes, state encoding and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package rsa_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned VALUE_BITS_DEF  = 48;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_ACC,
    VSEL_A,
    VSEL_SUM
  } val_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_OP,
    S_POPA,
    S_GETA,
    S_POPB,
    S_GETB,
    S_SUM,
    S_PRINT
  } state_t;

  typedef struct packed {
    logic     in_ready;
    logic     acc_digit;
    logic     push_acc;
    logic     drop_acc;
    logic     rd_top;
    logic     load_a;
    logic     clear_a;
    logic     load_b;
    logic     clear_b;
    logic     push_sum;
    logic     emit;
    kind_t    emit_kind;
    val_sel_t emit_sel;
    logic     emit_bad;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic eoi;
    logic is_digit;
    logic is_space;
    logic is_plus;
    logic is_nl;
    logic pending;
    logic empty;
    logic full;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/rsa_if.sv =====
// Valid/ready channel interfaces of the RPN stack adder: the character
// input channel and the result channel. No dependencies.
`default_nettype none

interface rsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface rsa_out_if #(
  parameter int unsigned VALUE_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [VALUE_BITS-1:0] value;
  logic [7:0]            bad_char;
  logic [7:0]            depth;
  logic                  last;

  modport source (output valid, output kind, output value, output bad_char,
                  output depth, output last, input ready);
  modport sink   (input valid, input kind, input value, input bad_char,
                  input depth, input last, output ready);
endinterface

`default_nettype wire

// ===== design/rpn_stack_adder.sv =====
// RPN stack adder: the top level, joining the controller and the datapath.
// Depends on rsa_pkg, rsa_if.sv, rsa_ctrl and rsa_dpath.
//
// Usage: characters arrive one item at a time on in_ch (valid/ready); an
// item with end_of_input set flushes a pending number instead. Results
// leave on out_ch (valid/ready), at most two per input item, the last one
// marked by last.
// Steps: each accepted item first passes the flush step; a digit then
// returns to idle, space or end of input end at the operator step, an
// unknown character reports there, a newline pops and prints a value
// and '+' pops two values and adds them, before the next item can be
// taken; a pop of an empty stack skips its capture step, and a pushed
// pending number adds no step. The stack memory has one read port with
// registered data, so each pop takes a read step and a capture step.
// Results land in an output register the cycle after they are formed; the
// block moves on while a result waits and stalls only when it has another
// result to give before the waiting one is taken.
// Reset (synchronous, active low) empties the stack, clears the pending
// number and drops any waiting result; the stack memory needs no clearing.
`default_nettype none

module rpn_stack_adder
  import rsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rsa_in_if.sink    in_ch,
  rsa_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  rsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rsa_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

// ===== design/rsa_dpath.sv =====
// Datapath of the RPN stack adder: input latch, number accumulator, value
// stack memory with its pointer, operand registers and the result register.
// Depends on rsa_pkg and the channel interfaces in rsa_if.sv.
`default_nettype none

module rsa_dpath
  import rsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rsa_in_if.sink     in_ch,
  rsa_out_if.source  out_ch,
  input  wire cmd_t  cmd,
  output sts_t       sts
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  logic [7:0]            char_r;
  logic                  eoi_r;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  pend_r, pend_nxt;
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;
  logic [VALUE_BITS-1:0] rdata_r;
  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];

  logic [SPW-1:0]        sp_dec;
  logic [VALUE_BITS+3:0] acc_ext;
  logic [VALUE_BITS+3:0] acc_mul;
  logic [VALUE_BITS:0]   sum_ext;
  logic [VALUE_BITS-1:0] sum;
  logic [VALUE_BITS-1:0] wdata;
  logic                  we;
  logic                  accept;

  logic                  out_valid_r;
  kind_t                 kind_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [7:0]            bad_r;
  logic [7:0]            depth_r;
  logic                  last_r;
  logic [VALUE_BITS-1:0] emit_val;

  assign in_ch.ready = cmd.in_ready;
  assign accept      = in_ch.valid && cmd.in_ready;

  // acc * 10 + digit, computed with four spare bits to detect saturation.
  assign acc_ext = {4'b0, acc_r};
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, char_r[3:0]};

  assign sum_ext = {1'b0, a_r} + {1'b0, b_r};
  assign sum     = sum_ext[VALUE_BITS] ? VMAX : sum_ext[VALUE_BITS-1:0];

  assign sp_dec = sp_r - SPW'(1);
  assign we     = cmd.push_acc || cmd.push_sum;
  assign wdata  = cmd.push_sum ? sum : acc_r;

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    if (cmd.acc_digit) begin
      acc_nxt  = (acc_mul > {4'b0, VMAX}) ? VMAX : acc_mul[VALUE_BITS-1:0];
      pend_nxt = 1'b1;
    end else if (cmd.push_acc || cmd.drop_acc) begin
      acc_nxt  = '0;
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    sp_nxt = sp_r;
    if (we) begin
      sp_nxt = sp_r + SPW'(1);
    end else if (cmd.rd_top) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= 1'b0;
      sp_r   <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      sp_r   <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_ch.char_code;
      eoi_r  <= in_ch.end_of_input;
    end
    if (cmd.load_a) begin
      a_r <= rdata_r;
    end else if (cmd.clear_a) begin
      a_r <= '0;
    end
    if (cmd.load_b) begin
      b_r <= rdata_r;
    end else if (cmd.clear_b) begin
      b_r <= '0;
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[sp_r[AW-1:0]] <= wdata;
    end
    if (cmd.rd_top) begin
      rdata_r <= mem[sp_dec[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      VSEL_ACC: emit_val = acc_r;
      VSEL_A:   emit_val = a_r;
      VSEL_SUM: emit_val = sum;
      default:  emit_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r  <= cmd.emit_kind;
      value_r <= emit_val;
      bad_r   <= cmd.emit_bad ? char_r : 8'h00;
      depth_r <= 8'(sp_r);
      last_r  <= cmd.emit_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.value    = value_r;
  assign out_ch.bad_char = bad_r;
  assign out_ch.depth    = depth_r;
  assign out_ch.last     = last_r;

  assign sts.in_valid  = in_ch.valid;
  assign sts.eoi       = eoi_r;
  assign sts.is_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign sts.is_space  = char_r == CH_SPACE;
  assign sts.is_plus   = char_r == CH_PLUS;
  assign sts.is_nl     = char_r == CH_NL;
  assign sts.pending   = pend_r;
  assign sts.empty     = sp_r == '0;
  assign sts.full      = sp_r == SPW'(STACK_DEPTH);
  assign sts.slot_free = !out_valid_r || out_ch.ready;

endmodule

`default_nettype wire

// ===== design/rsa_ctrl.sv =====
// Controller of the RPN stack adder: sequences each character through
// number flush, stack pops, push and result emission.
// Depends on rsa_pkg.
`default_nettype none

module rsa_ctrl
  import rsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   other;

  assign other = !sts.is_space && !sts.is_plus && !sts.is_nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.eoi && sts.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!sts.pending) begin
          state_nxt = S_OP;
        end else if (!sts.full) begin
          cmd.push_acc = 1'b1;
          state_nxt    = S_OP;
        end else if (sts.slot_free) begin
          // The dropped number is the final result unless a newline or an
          // unknown character still has to report.
          cmd.drop_acc  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FULL;
          cmd.emit_sel  = VSEL_ACC;
          cmd.emit_last = sts.eoi || sts.is_space || sts.is_plus;
          state_nxt     = S_OP;
        end
      end
      S_OP: begin
        if (sts.eoi || sts.is_space) begin
          state_nxt = S_IDLE;
        end else if (!other) begin
          state_nxt = S_POPA;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_UNKNOWN;
          cmd.emit_sel  = VSEL_ZERO;
          cmd.emit_bad  = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_POPA: begin
        if (!sts.empty) begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_GETA;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_EMPTY;
          cmd.emit_sel  = VSEL_ZERO;
          cmd.clear_a   = 1'b1;
          state_nxt     = sts.is_plus ? S_POPB : S_PRINT;
        end
      end
      S_GETA: begin
        cmd.load_a = 1'b1;
        state_nxt  = sts.is_plus ? S_POPB : S_PRINT;
      end
      S_POPB: begin
        if (!sts.empty) begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_GETB;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_EMPTY;
          cmd.emit_sel  = VSEL_ZERO;
          cmd.emit_last = 1'b1;
          cmd.clear_b   = 1'b1;
          state_nxt     = S_SUM;
        end
      end
      S_GETB: begin
        cmd.load_b = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        if (!sts.full) begin
          cmd.push_sum = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FULL;
          cmd.emit_sel  = VSEL_SUM;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PRINT: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_VALUE;
          cmd.emit_sel  = VSEL_A;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
